// ===== sv/glo_pkg.sv =====
`default_nettype none

package glo_pkg;

    // fixed field widths
    localparam int unsigned COORD_W = 10;
    localparam int unsigned TOTAL_W = 21;
    localparam int unsigned HIT_W   = 2;

    // hit counter saturation point and total ceiling
    localparam logic [HIT_W-1:0]   HIT_LIMIT = 2'd2;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // one segment beat
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } seg_beat_t;

    // one result beat
    typedef struct packed {
        logic [TOTAL_W-1:0] overlap_cells;
        logic               drawn;
    } res_beat_t;

endpackage

`default_nettype wire

// ===== sv/glo_ram.sv =====
`default_nettype none

module glo_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/grid_line_overlap_counter.sv =====
`default_nettype none

// Grid line overlap counter. Each segment beat carries two end points on a square
// grid; horizontal and vertical segments, and 45-degree ones while diagonal mode
// is on (cfg_wdata = 1 on a cfg_we pulse, on after reset), are walked one cell per
// clock, and each covered cell's 2-bit hit count in the cell RAM is read, bumped
// (saturating at 2) and written back. The result beat gives the running number of
// cells hit at least twice and whether the segment was drawn. A drawn segment is
// walked, then the single read-modify-write pass through the cell RAM drains before
// its result is given; an ignored one goes straight to its result. One segment
// is in flight at a time, and the next is taken while a result still waits.
// After reset all min(GRID_SIZE, 1024) squared entries of the cell RAM are cleared,
// one entry per clock, during which no segment is accepted.
module grid_line_overlap_counter
    import glo_pkg::*;
#(
    parameter int unsigned GRID_SIZE = 1024
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      seg_valid,
    output logic           seg_stall,
    input  wire seg_beat_t seg,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_beat_t      res,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata
);

    // only cells reachable by 10-bit coordinates are stored
    localparam int unsigned DIM    = (GRID_SIZE < 1024) ? GRID_SIZE : 1024;
    localparam int unsigned CELLS  = DIM * DIM;
    localparam int unsigned ADDR_W = $clog2(CELLS);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic diag_en_reg;

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [COORD_W-1:0] x1_reg, x1_next;
    logic [COORD_W-1:0] y1_reg, y1_next;
    logic               drawn_reg, drawn_next;

    logic              v1_reg, v1_next;
    logic [ADDR_W-1:0] addr1_reg;
    logic              v2_reg;
    logic [ADDR_W-1:0] addr2_reg;

    logic [TOTAL_W-1:0] total_reg, total_next;

    logic      res_valid_reg, res_valid_next;
    res_beat_t res_reg, res_next;

    logic [COORD_W-1:0] dx, dy;
    logic               draw;
    logic               seg_take;
    logic               at_end;
    logic               in_grid;
    logic               res_free;

    logic [HIT_W-1:0]  rd_hits;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [HIT_W-1:0]  ram_wdata;
    logic              hit_bump;

    assign seg_stall = (state_reg != ST_IDLE);
    assign seg_take  = seg_valid && !seg_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign res_free  = !res_valid_reg || !res_stall;

    // segment classification
    always_comb
    begin
        dx   = (seg.start_x < seg.end_x) ? (seg.end_x - seg.start_x)
                                         : (seg.start_x - seg.end_x);
        dy   = (seg.start_y < seg.end_y) ? (seg.end_y - seg.start_y)
                                         : (seg.start_y - seg.end_y);
        draw = (dx == '0) || (dy == '0) || (diag_en_reg && (dx == dy));
    end

    assign at_end  = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign in_grid = ({1'b0, x_reg} < (COORD_W + 1)'(DIM))
                  && ({1'b0, y_reg} < (COORD_W + 1)'(DIM));

    // sequencer and walker
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        drawn_next    = drawn_reg;
        v1_next       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (seg_take)
                begin
                    x_next     = seg.start_x;
                    y_next     = seg.start_y;
                    x1_next    = seg.end_x;
                    y1_next    = seg.end_y;
                    drawn_next = draw;
                    state_next = draw ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK:
            begin
                v1_next = in_grid;
                if (x_reg < x1_reg)
                begin
                    x_next = x_reg + 1'b1;
                end
                else if (x_reg > x1_reg)
                begin
                    x_next = x_reg - 1'b1;
                end
                if (y_reg < y1_reg)
                begin
                    y_next = y_reg + 1'b1;
                end
                else if (y_reg > y1_reg)
                begin
                    y_next = y_reg - 1'b1;
                end
                if (at_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read-modify-write of the hit count
    always_comb
    begin
        hit_bump   = v2_reg && (rd_hits < HIT_LIMIT);
        total_next = total_reg;
        if (hit_bump && ((rd_hits + 1'b1) == HIT_LIMIT) && (total_reg != TOTAL_MAX))
        begin
            total_next = total_reg + 1'b1;
        end
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = hit_bump;
            ram_waddr = addr2_reg;
            ram_wdata = rd_hits + 1'b1;
        end
    end

    // result slot
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if ((state_reg == ST_DONE) && res_free)
        begin
            res_valid_next         = 1'b1;
            res_next.overlap_cells = total_reg;
            res_next.drawn         = drawn_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            diag_en_reg   <= 1'b1;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                diag_en_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        drawn_reg <= drawn_next;
        addr1_reg <= ADDR_W'(y_reg) * ADDR_W'(DIM) + ADDR_W'(x_reg);
        addr2_reg <= addr1_reg;
        res_reg   <= res_next;
    end

    // cell hit store
    glo_ram #(
        .WIDTH (HIT_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (addr1_reg),
        .rd_data (rd_hits)
    );

endmodule

`default_nettype wire
